/* rtl/core/lpfr_pkg.sv */
// Package: shared constants, codes and types for the length-prefixed frame receiver.
`timescale 1ns / 1ps
`default_nettype none
package lpfr_pkg;

    localparam int MAX_CAPACITY = 256;
    localparam int CNT_W        = $clog2(MAX_CAPACITY + 1);

    localparam int CAP_W  = 9;
    localparam int TICK_W = 32;
    localparam int LEN_W  = 17;

    localparam logic [7:0]       START_BYTE  = 8'hAA;
    localparam logic [LEN_W-1:0] HEADER_LEN  = LEN_W'(5);
    localparam logic [LEN_W-1:0] TRAILER_LEN = LEN_W'(2);
    localparam logic [CNT_W-1:0] LEN_HI_POS  = CNT_W'(4);

    localparam logic [TICK_W-1:0] CAPACITY_RESET = TICK_W'(10);
    localparam logic [TICK_W-1:0] TIMEOUT_RESET  = TICK_W'(1000);

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        EV_STORED   = 2'd0,
        EV_COMPLETE = 2'd1,
        EV_TIMEOUT  = 2'd2
    } event_t;

    typedef enum logic {
        REG_CAPACITY = 1'b0,
        REG_TIMEOUT  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic             valid;
        logic [1:0]       evt;
        logic [7:0]       byte_index;
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] frame_length;
    } lpfr_result_t;

endpackage
`default_nettype wire

/* rtl/core/lpfr_state.sv */
// Receive state registers and the per-transaction update and result logic.
`timescale 1ns / 1ps
`default_nettype none
module lpfr_state (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        item_accept,
    input  wire logic [1:0]                  opcode,
    input  wire logic [7:0]                  rx_byte,
    input  wire logic [lpfr_pkg::CAP_W-1:0]  capacity,
    input  wire logic [lpfr_pkg::TICK_W-1:0] timeout_ticks,
    output lpfr_pkg::lpfr_result_t           result
);

    logic                        active_reg,       active_next;
    logic [lpfr_pkg::CNT_W-1:0]  count_reg,        count_next;
    logic [7:0]                  len_hi_reg,       len_hi_next;
    logic [lpfr_pkg::LEN_W-1:0]  exp_len_reg,      exp_len_next;
    logic                        len_known_reg,    len_known_next;
    logic [lpfr_pkg::TICK_W-1:0] ticks_reg,        ticks_next;

    logic [lpfr_pkg::CNT_W-1:0]  cap_eff;
    logic [lpfr_pkg::CNT_W-1:0]  count_inc;
    logic [lpfr_pkg::TICK_W-1:0] ticks_inc;
    logic                        expired;

    always_comb begin
        if (32'(capacity) > 32'(lpfr_pkg::MAX_CAPACITY)) begin
            cap_eff = lpfr_pkg::CNT_W'(lpfr_pkg::MAX_CAPACITY);
        end else begin
            cap_eff = lpfr_pkg::CNT_W'(capacity);
        end
    end

    assign count_inc = count_reg + lpfr_pkg::CNT_W'(1);
    assign ticks_inc = (ticks_reg == '1) ? ticks_reg : ticks_reg + lpfr_pkg::TICK_W'(1);
    assign expired   = (ticks_reg >= timeout_ticks);

    always_comb begin
        active_next    = active_reg;
        count_next     = count_reg;
        len_hi_next    = len_hi_reg;
        exp_len_next   = exp_len_reg;
        len_known_next = len_known_reg;
        ticks_next     = ticks_reg;
        result         = '0;

        case (lpfr_pkg::opcode_t'(opcode))
            lpfr_pkg::OP_START: begin
                active_next    = 1'b1;
                count_next     = '0;
                len_hi_next    = '0;
                exp_len_next   = '0;
                len_known_next = 1'b0;
                ticks_next     = '0;
            end
            lpfr_pkg::OP_TICK: begin
                if (active_reg) begin
                    ticks_next = ticks_inc;
                    if (ticks_inc >= timeout_ticks) begin
                        active_next         = 1'b0;
                        result.valid        = 1'b1;
                        result.evt          = lpfr_pkg::EV_TIMEOUT;
                        result.frame_length = len_known_reg ? exp_len_reg : '0;
                    end
                end
            end
            lpfr_pkg::OP_BYTE: begin
                if (active_reg && !expired
                        && !(count_reg == '0 && rx_byte != lpfr_pkg::START_BYTE)
                        && (count_reg < cap_eff)) begin
                    count_next = count_inc;
                    if (count_inc == lpfr_pkg::LEN_HI_POS) begin
                        len_hi_next = rx_byte;
                    end
                    if (32'(count_inc) >= 32'(lpfr_pkg::HEADER_LEN) && !len_known_reg) begin
                        exp_len_next   = lpfr_pkg::HEADER_LEN + lpfr_pkg::TRAILER_LEN
                                       + lpfr_pkg::LEN_W'({len_hi_next, rx_byte});
                        len_known_next = 1'b1;
                    end
                    result.valid        = 1'b1;
                    result.byte_index   = count_reg[7:0];
                    result.data_byte    = rx_byte;
                    result.frame_length = len_known_next ? exp_len_next : '0;
                    if (len_known_next && lpfr_pkg::LEN_W'(count_inc) >= exp_len_next) begin
                        active_next = 1'b0;
                        result.evt  = lpfr_pkg::EV_COMPLETE;
                    end else begin
                        result.evt  = lpfr_pkg::EV_STORED;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            count_reg     <= '0;
            len_hi_reg    <= '0;
            exp_len_reg   <= '0;
            len_known_reg <= 1'b0;
            ticks_reg     <= '0;
        end else if (item_accept) begin
            active_reg    <= active_next;
            count_reg     <= count_next;
            len_hi_reg    <= len_hi_next;
            exp_len_reg   <= exp_len_next;
            len_known_reg <= len_known_next;
            ticks_reg     <= ticks_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/length_prefixed_frame_receiver.sv */
// Top level: length-prefixed frame receiver with tick timeout.
//
//  channel | direction | handshake              | payload
//  s_      | in        | s_valid / s_ready      | s_opcode, s_rx_byte
//  m_      | out       | m_valid / m_ready      | m_event_res, m_byte_index,
//          |           |                        | m_data_byte, m_frame_length
//  cfg_    | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One input transaction per cycle while s_ready is high; its result appears in the output register
// on the next cycle. s_ready is high whenever the output register is empty or
// being drained this cycle, so stalls come only from m_ready.
// Synchronous active-low reset; the config port is always ready.
`timescale 1ns / 1ps
`default_nettype none
module length_prefixed_frame_receiver (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,

    input  wire logic                        s_valid,
    output      logic                        s_ready,
    input  wire logic [1:0]                  s_opcode,
    input  wire logic [7:0]                  s_rx_byte,

    output      logic                        m_valid,
    input  wire logic                        m_ready,
    output      logic [1:0]                  m_event_res,
    output      logic [7:0]                  m_byte_index,
    output      logic [7:0]                  m_data_byte,
    output      logic [lpfr_pkg::LEN_W-1:0]  m_frame_length,

    input  wire logic                        cfg_valid,
    output      logic                        cfg_ready,
    input  wire logic                        cfg_index,
    input  wire logic [lpfr_pkg::TICK_W-1:0] cfg_data
);

    logic [lpfr_pkg::CAP_W-1:0]  capacity_reg;
    logic [lpfr_pkg::TICK_W-1:0] timeout_reg;

    logic                        out_valid_reg, out_valid_next;
    lpfr_pkg::lpfr_result_t      out_reg;
    lpfr_pkg::lpfr_result_t      result;
    logic                        item_accept;

    assign cfg_ready   = 1'b1;
    assign s_ready     = !out_valid_reg || m_ready;
    assign item_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= lpfr_pkg::CAP_W'(lpfr_pkg::CAPACITY_RESET);
            timeout_reg  <= lpfr_pkg::TIMEOUT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (lpfr_pkg::cfg_reg_t'(cfg_index))
                lpfr_pkg::REG_CAPACITY: capacity_reg <= cfg_data[lpfr_pkg::CAP_W-1:0];
                lpfr_pkg::REG_TIMEOUT:  timeout_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    lpfr_state u_state (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_accept   (item_accept),
        .opcode        (s_opcode),
        .rx_byte       (s_rx_byte),
        .capacity      (capacity_reg),
        .timeout_ticks (timeout_reg),
        .result        (result)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (item_accept && result.valid) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_accept && result.valid) begin
            out_reg <= result;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_event_res    = out_reg.evt;
    assign m_byte_index   = out_reg.byte_index;
    assign m_data_byte    = out_reg.data_byte;
    assign m_frame_length = out_reg.frame_length;

endmodule
`default_nettype wire

/* rtl/core/lpfr_checker.sv */
// Port-level assertions for the frame receiver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lpfr_checker (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       m_valid,
    input wire logic                       m_ready,
    input wire logic [1:0]                 m_event_res,
    input wire logic [7:0]                 m_byte_index,
    input wire logic [7:0]                 m_data_byte,
    input wire logic [lpfr_pkg::LEN_W-1:0] m_frame_length
);

    localparam logic [lpfr_pkg::LEN_W-1:0] MIN_FRAME =
        lpfr_pkg::HEADER_LEN + lpfr_pkg::TRAILER_LEN;

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_res)
            && $stable(m_byte_index) && $stable(m_data_byte) && $stable(m_frame_length))
        else $error("stalled result changed");

    a_event_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_event_res == lpfr_pkg::EV_STORED
            || m_event_res == lpfr_pkg::EV_COMPLETE
            || m_event_res == lpfr_pkg::EV_TIMEOUT)
        else $error("bad event code");

    a_timeout_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == lpfr_pkg::EV_TIMEOUT |->
            m_byte_index == 8'd0 && m_data_byte == 8'd0)
        else $error("timeout carries byte data");

    a_length_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_length != '0 |-> m_frame_length >= MIN_FRAME)
        else $error("frame length below header plus trailer");

endmodule

bind length_prefixed_frame_receiver lpfr_checker u_lpfr_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_event_res    (m_event_res),
    .m_byte_index   (m_byte_index),
    .m_data_byte    (m_data_byte),
    .m_frame_length (m_frame_length)
);
`default_nettype wire

/* tb/tb.sv */
// Testbench for the length-prefixed frame receiver: random framed traffic against a predictor.
`timescale 1ns / 1ps
module tb;
    import lpfr_pkg::*;

    localparam logic [1:0] OP_RESERVED = 2'd3;

    typedef struct {
        event_t           ev;
        logic [7:0]       idx;
        logic [7:0]       data;
        logic [LEN_W-1:0] flen;
    } frame_event_t;

    class frame_scoreboard;
        logic [CAP_W-1:0]  capacity_reg;
        logic [TICK_W-1:0] tick_limit;
        bit                armed;
        logic [CAP_W-1:0]  stored;
        logic [7:0]        len_hi;
        logic [LEN_W-1:0]  frame_len;
        bit                len_known;
        logic [TICK_W-1:0] ticks;
        frame_event_t      expected_events[$];
        int                mismatches;
        int                bytes_stored;
        int                frames_done;
        int                timeouts;

        function new();
            capacity_reg = CAPACITY_RESET[CAP_W-1:0];
            tick_limit   = TIMEOUT_RESET;
            armed        = 1'b0;
            clear_frame();
        endfunction

        function void clear_frame();
            stored    = '0;
            len_hi    = '0;
            frame_len = '0;
            len_known = 1'b0;
            ticks     = '0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [TICK_W-1:0] val);
            if (idx == REG_CAPACITY) begin
                capacity_reg = val[CAP_W-1:0];
            end else begin
                tick_limit = val;
            end
        endfunction

        function void push_event(event_t ev, logic [7:0] idx, logic [7:0] data);
            expected_events.push_back('{ev, idx, data, len_known ? frame_len : '0});
        endfunction

        // returns 1 when the transaction was acted on rather than ignored
        function bit note_input(logic [1:0] op, logic [7:0] b);
            logic [CAP_W-1:0] cap_eff;
            logic [7:0]       idx;
            case (op)
                OP_START: begin
                    armed = 1'b1;
                    clear_frame();
                    return 1'b1;
                end
                OP_TICK: begin
                    if (!armed) return 1'b0;
                    if (ticks != '1) ticks++;
                    if (ticks >= tick_limit) begin
                        armed = 1'b0;
                        push_event(EV_TIMEOUT, 8'd0, 8'd0);
                        timeouts++;
                    end
                    return 1'b1;
                end
                OP_BYTE: begin
                    if (!armed || ticks >= tick_limit) return 1'b0;
                    if (stored == 0 && b != START_BYTE) return 1'b0;
                    cap_eff = (capacity_reg > MAX_CAPACITY) ? CAP_W'(MAX_CAPACITY) : capacity_reg;
                    if (stored >= cap_eff) return 1'b0;
                    idx = stored[7:0];
                    stored++;
                    bytes_stored++;
                    if (stored == 4) len_hi = b;
                    if (stored >= 5 && !len_known) begin
                        frame_len = HEADER_LEN + LEN_W'({len_hi, b}) + TRAILER_LEN;
                        len_known = 1'b1;
                    end
                    if (len_known && stored >= frame_len) begin
                        armed = 1'b0;
                        push_event(EV_COMPLETE, idx, b);
                        frames_done++;
                    end else begin
                        push_event(EV_STORED, idx, b);
                    end
                    return 1'b1;
                end
                default: return 1'b0;
            endcase
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("MISMATCH @%0t: %s", $realtime, what);
        endtask

        task check_result(logic [1:0] ev, logic [7:0] idx, logic [7:0] data,
                          logic [LEN_W-1:0] flen);
            frame_event_t exp;
            if (expected_events.size() == 0) begin
                report_mismatch($sformatf("unexpected result ev=%0d idx=%0d data=%02h len=%0d",
                                          ev, idx, data, flen));
                return;
            end
            exp = expected_events.pop_front();
            if (ev !== exp.ev)
                report_mismatch($sformatf("event %0d, expected %0d", ev, exp.ev));
            if (idx !== exp.idx)
                report_mismatch($sformatf("byte_index %0d, expected %0d", idx, exp.idx));
            if (data !== exp.data)
                report_mismatch($sformatf("data_byte %02h, expected %02h", data, exp.data));
            if (flen !== exp.flen)
                report_mismatch($sformatf("frame_length %0d, expected %0d", flen, exp.flen));
        endtask
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [1:0]          s_opcode;
    logic [7:0]          s_rx_byte;
    logic                m_valid;
    logic                m_ready;
    logic [1:0]          m_event_res;
    logic [7:0]          m_byte_index;
    logic [7:0]          m_data_byte;
    logic [LEN_W-1:0]    m_frame_length;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_index;
    logic [TICK_W-1:0]   cfg_data;

    frame_scoreboard sb;
    int burst_left;
    int accepted_items;
    int acted_items;
    int cfg_writes;
    int stall_mode;
    int stall_left;
    int stall_phase;

    length_prefixed_frame_receiver DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_res    (m_event_res),
        .m_byte_index   (m_byte_index),
        .m_data_byte    (m_data_byte),
        .m_frame_length (m_frame_length),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("tb NOT OK");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                sb.check_result(m_event_res, m_byte_index, m_data_byte, m_frame_length);
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 200);
            end
            stall_left--;
            stall_phase++;
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= (stall_phase % 5 == 0);
            endcase
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 16);
        end
        s_valid   <= 1'b1;
        s_opcode  <= op;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (sb.note_input(op, b)) acted_items++;
        accepted_items++;
        burst_left--;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [TICK_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
        cfg_writes++;
        @(posedge aclk);
    endtask

    // hold the sender until every result is out
    task automatic wait_drained();
        s_valid    <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (sb.expected_events.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic send_frame();
        logic [15:0] plen;
        logic [7:0]  b;
        int          total;
        int          cut;
        send_item(OP_START, rand_byte());
        repeat ($urandom_range(0, 3)) begin
            b = rand_byte();
            if (b == START_BYTE) b = ~b;
            send_item(OP_BYTE, b);
        end
        case ($urandom_range(0, 19))
            0: plen = 16'($urandom_range(0, 65535));
            1: plen = 16'($urandom_range(200, 300));
            default: plen = 16'($urandom_range(0, 12));
        endcase
        total = 7 + plen;
        cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, total) : total;
        if (cut > 320) cut = 320;
        for (int i = 0; i < cut; i++) begin
            case (i)
                0: b = START_BYTE;
                3: b = plen[15:8];
                4: b = plen[7:0];
                default: b = rand_byte();
            endcase
            if ($urandom_range(0, 9) == 0) send_item(OP_TICK, rand_byte());
            if ($urandom_range(0, 59) == 0) send_item(OP_RESERVED, rand_byte());
            if ($urandom_range(0, 99) == 0) send_item(OP_START, rand_byte());
            send_item(OP_BYTE, b);
        end
        repeat ($urandom_range(0, 2))
            send_item($urandom_range(0, 1) ? OP_TICK : OP_BYTE, rand_byte());
    endtask

    initial begin
        logic [TICK_W-1:0] val;
        int                drain;
        sb          = new();
        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_opcode   <= OP_START;
        s_rx_byte  <= 8'd0;
        m_ready    <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= REG_CAPACITY;
        cfg_data   <= '0;
        burst_left = 0;
        stall_left = 0;
        stall_phase = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // idle receiver, reserved opcode, hunting, a minimal complete frame
        send_item(OP_BYTE, START_BYTE);
        send_item(OP_TICK, 8'h00);
        send_item(OP_RESERVED, 8'hFF);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, START_BYTE);
        send_item(OP_BYTE, 8'h55);
        send_item(OP_BYTE, 8'h01);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, START_BYTE);
        // restart while armed
        send_item(OP_START, 8'hFF);
        send_item(OP_BYTE, START_BYTE);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, START_BYTE);
        send_item(OP_BYTE, 8'h00);
        // full buffer, then timeout
        wait_drained();
        write_reg(REG_CAPACITY, 32'd1);
        write_reg(REG_TIMEOUT, 32'd2);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, START_BYTE);
        send_item(OP_BYTE, START_BYTE);
        send_item(OP_TICK, 8'h00);
        send_item(OP_TICK, 8'hFF);
        // zero capacity and an already expired receive
        wait_drained();
        write_reg(REG_CAPACITY, 32'd0);
        write_reg(REG_TIMEOUT, 32'd0);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, START_BYTE);
        send_item(OP_TICK, 8'h00);

        while (accepted_items < 1000) begin
            wait_drained();
            case ($urandom_range(0, 7))
                0, 1: val = MAX_CAPACITY;
                2, 3: val = $urandom_range(7, 40);
                4: val = $urandom_range(1, 6);
                5: val = $urandom_range(MAX_CAPACITY + 1, 511);
                6: val = $urandom_range(41, 255);
                default: val = $urandom_range(0, 1);
            endcase
            val[TICK_W-1:CAP_W] = (TICK_W-CAP_W)'($urandom());
            write_reg(REG_CAPACITY, val);
            case ($urandom_range(0, 7))
                0: val = $urandom_range(1, 6);
                1, 2: val = $urandom_range(20, 80);
                3: val = TIMEOUT_RESET;
                4: val = '1;
                5: val = '0;
                6: val = $urandom();
                default: val = $urandom_range(100, 400);
            endcase
            write_reg(REG_TIMEOUT, val);
            repeat ($urandom_range(2, 8)) send_frame();
        end

        s_valid <= 1'b0;
        drain = 0;
        while (sb.expected_events.size() != 0 && drain < 100000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (10) @(posedge aclk);
        if (sb.expected_events.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived",
                                         sb.expected_events.size()));
        $display("Covered %0d transactions (%0d acted on) over %0d register writes:",
                 accepted_items, acted_items, cfg_writes);
        $display("  %0d bytes stored, %0d frames completed, %0d timeouts",
                 sb.bytes_stored, sb.frames_done, sb.timeouts);
        if (sb.mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule

/* length_prefixed_frame_receiver.f */
rtl/core/lpfr_pkg.sv
rtl/core/lpfr_state.sv
rtl/core/length_prefixed_frame_receiver.sv
rtl/core/lpfr_checker.sv
tb/tb.sv
